### hdl/ipv4_longest_prefix_route_table_macros.svh
// ----------------------------------------------------------------------------
// IPv4 route table assertion macros
// Shared property forms for the route table checks.
// ----------------------------------------------------------------------------
`ifndef IPV4_LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH

// same-cycle implication
`define LPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the route table modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int ADDR_W      = 32;
  localparam int IFC_W       = 4;
  localparam int PLEN_W      = 6;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DEL    = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway_in;
    logic [IFC_W-1:0]  interface_in;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [ADDR_W-1:0] next_gateway;
    logic [IFC_W-1:0]  next_interface;
    logic [PLEN_W-1:0] match_length;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_status_t;

endpackage

### hdl/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: clearing pass after reset, then one table scan per item.
// ----------------------------------------------------------------------------
module lpr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lpr_pkg::dp_status_t stat,
  output logic                busy,
  output lpr_pkg::ctrl_cmd_t  cmd
);
  import lpr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.cnt_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    cmd.clear_wr = (state_r == ST_CLEAR);
    cmd.scan_rd  = (state_r == ST_SCAN);
    cmd.finish   = (state_r == ST_FINISH);
    if (state_r == ST_IDLE) begin
      busy     = 1'b0;
      cmd.load = start;
    end
  end

endmodule

### hdl/lpr_dpath.sv
// ----------------------------------------------------------------------------
// lpr_dpath
// Entry memories, scan counter, match tracking and result register.
// ----------------------------------------------------------------------------
module lpr_dpath #(
  parameter int ENTRIES = lpr_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpr_pkg::ctrl_cmd_t  cmd,
  input  lpr_pkg::in_item_t   in_item,
  output lpr_pkg::dp_status_t stat,
  output logic                out_valid,
  output lpr_pkg::out_item_t  out_item
);
  import lpr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] mask;
    logic [PLEN_W-1:0] plen;
  } key_t;

  typedef struct packed {
    logic [ADDR_W-1:0] gateway;
    logic [IFC_W-1:0]  ifc;
  } data_t;

  function automatic logic [PLEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
    logic [PLEN_W-1:0] n;
    n = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      n = n + PLEN_W'(v[b]);
    end
    return n;
  endfunction

  key_t  key_mem [ENTRIES];
  data_t dat_mem [ENTRIES];

  in_item_t          item_r;
  logic [ADDR_W-1:0] net_masked_r;
  logic [PLEN_W-1:0] plen_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  key_t              key_rd_r;
  data_t             dat_rd_r;
  logic              hit_found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              best_found_r;
  logic [PLEN_W-1:0] best_plen_r;
  data_t             best_dat_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              cnt_last;
  logic              same_hit;
  logic              lk_match;
  logic              key_we;
  logic [IDX_W-1:0]  key_wa;
  key_t              key_wd;
  logic              dat_we;
  logic [IDX_W-1:0]  dat_wa;
  data_t             dat_wd;
  out_item_t         res;

  assign cnt_last      = (cnt_r == IDX_W'(ENTRIES - 1));
  assign stat.cnt_last = cnt_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear_wr || cmd.scan_rd) begin
      cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r       <= in_item;
      net_masked_r <= in_item.address & in_item.mask;
      plen_r       <= ones_in(in_item.mask);
    end
  end

  // entry memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (dat_we) dat_mem[dat_wa] <= dat_wd;
    if (cmd.scan_rd) begin
      key_rd_r <= key_mem[cnt_r];
      dat_rd_r <= dat_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
  end

  assign same_hit = key_rd_r.valid && (key_rd_r.plen == plen_r) &&
                    ((key_rd_r.network & item_r.mask) == net_masked_r);
  assign lk_match = key_rd_r.valid &&
                    ((item_r.address & key_rd_r.mask) ==
                     (key_rd_r.network & key_rd_r.mask));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (same_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= rd_idx_r;
      end
      if (!key_rd_r.valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (lk_match && (!best_found_r || (key_rd_r.plen > best_plen_r))) begin
        best_found_r <= 1'b1;
        best_plen_r  <= key_rd_r.plen;
        best_dat_r   <= dat_rd_r;
      end
    end
  end

  always_comb begin
    res    = '0;
    key_we = cmd.clear_wr;
    key_wa = cnt_r;
    key_wd = '0;
    dat_we = 1'b0;
    dat_wa = hit_idx_r;
    dat_wd = '{gateway: item_r.gateway_in, ifc: item_r.interface_in};
    if (cmd.finish) begin
      unique case (item_r.mode)
        MODE_ADD: begin
          if (hit_found_r) begin
            dat_we = 1'b1;
          end else if (free_found_r) begin
            key_we = 1'b1;
            key_wa = free_idx_r;
            key_wd = '{valid: 1'b1, network: item_r.address,
                       mask: item_r.mask, plen: plen_r};
            dat_we = 1'b1;
            dat_wa = free_idx_r;
          end else begin
            res.status = 1'b1;
          end
        end
        MODE_DEL: begin
          key_we = hit_found_r;
          key_wa = hit_idx_r;
        end
        MODE_LOOKUP: begin
          if (best_found_r) begin
            res.found          = 1'b1;
            res.next_gateway   = best_dat_r.gateway;
            res.next_interface = best_dat_r.ifc;
            res.match_length   = best_plen_r;
          end
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hdl/ipv4_longest_prefix_route_table.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_route_table
// IPv4 route table with add, delete and longest-prefix lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the item is taken on a clock edge where
//   start is high and busy is low. busy stays high while the item runs.
//   Every item, whatever its mode, gives one result: out_item is valid for
//   exactly one cycle while out_valid is high, and the receiver must take
//   it then, as it cannot stall the block.
//   Each item reads every table entry once, one entry a cycle from the
//   single read port of each entry memory in ST_SCAN, then checks the last
//   read in ST_DRAIN and updates the table in ST_FINISH. out_valid is
//   registered from the table update; a new item can be taken once busy is
//   low again. After reset the block clears the valid mark of every entry,
//   one entry a cycle, with busy high; then it takes items.
// ----------------------------------------------------------------------------
`include "ipv4_longest_prefix_route_table_macros.svh"

module ipv4_longest_prefix_route_table #(
  parameter int ENTRIES = lpr_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output lpr_pkg::out_item_t out_item
);
  import lpr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  lpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpr_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `LPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepting an item")
  `LPR_ASSERT_NEXT(a_finish_result, cmd.finish, out_valid, "no result after table update")
  `LPR_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while still busy")
  `LPR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")

endmodule
